### sv/pid_controller_pos_incr_assert.svh
// Assertion macros for the PID controller block.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef PID_CONTROLLER_POS_INCR_ASSERT_SVH
`define PID_CONTROLLER_POS_INCR_ASSERT_SVH

// Same-cycle implication.
`define PID_PI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pid controller: same-cycle check failed");

// Next-cycle implication.
`define PID_PI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pid controller: next-cycle check failed");

`endif

### sv/pid_pi_pkg.sv
`timescale 1ns / 1ps

package pid_pi_pkg;

    localparam int MEAS_W     = 24;
    localparam int ERR_W      = MEAS_W + 1;
    localparam int SUM_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int OUT_W      = 32;
    localparam int FRAC_BITS  = 8;
    localparam int OP_P_W     = ERR_W + 1;
    localparam int OP_I_W     = SUM_W;
    localparam int OP_D_W     = ERR_W + 2;
    localparam int PROD_P_W   = GAIN_W + OP_P_W;
    localparam int PROD_I_W   = GAIN_W + OP_I_W;
    localparam int PROD_D_W   = GAIN_W + OP_D_W;
    localparam int ACC_W      = PROD_I_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        MODE_P   = 2'd0,
        MODE_PI  = 2'd1,
        MODE_POS = 2'd2,
        MODE_INC = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_TARGET = 3'd1,
        CFG_GAIN_P = 3'd2,
        CFG_GAIN_I = 3'd3,
        CFG_GAIN_D = 3'd4
    } t_cfg_idx;

    localparam t_mode                     RST_MODE   = MODE_POS;
    localparam logic signed [MEAS_W-1:0]  RST_TARGET = 24'sd512;
    localparam logic signed [GAIN_W-1:0]  RST_GAIN_P = 16'sd486;
    localparam logic signed [GAIN_W-1:0]  RST_GAIN_I = 16'sd128;
    localparam logic signed [GAIN_W-1:0]  RST_GAIN_D = 16'sd0;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [OP_P_W-1:0] p;
        logic signed [OP_I_W-1:0] i;
        logic signed [OP_D_W-1:0] d;
        logic                     sum_hit;
    } t_ops;

endpackage

### sv/pid_pi_state.sv
`timescale 1ns / 1ps

module pid_pi_state
    import pid_pi_pkg::*;
#(
    parameter int ERR_CLAMP = 256000
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  t_mode                   i_mode,
    input  logic signed [ERR_W-1:0] i_err,
    output t_ops                    o_ops
);

    localparam int CLAMP_W = $clog2(ERR_CLAMP + 1) + 1;
    localparam logic signed [ERR_W-1:0] CLAMP_HI = ERR_W'(ERR_CLAMP);
    localparam logic signed [ERR_W-1:0] CLAMP_LO = -CLAMP_HI;

    logic signed [ERR_W-1:0]   r_last_err;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [SUM_W-1:0]   r_err_sum;

    logic signed [SUM_W:0]     sum_wide;
    logic                      sum_hit;
    logic signed [SUM_W-1:0]   sum_new;
    logic signed [ERR_W-1:0]   clamp_full;
    logic signed [CLAMP_W-1:0] clamp_err;
    logic signed [OP_P_W-1:0]  inc_p;
    logic signed [OP_D_W-1:0]  inc_d;
    logic signed [OP_P_W-1:0]  pos_d;

    always_comb begin
        sum_wide = (SUM_W+1)'(r_err_sum) + (SUM_W+1)'(i_err);
        sum_hit  = sum_wide[SUM_W] != sum_wide[SUM_W-1];
        if (sum_hit) begin
            sum_new = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_new = sum_wide[SUM_W-1:0];
        end

        if (i_err > CLAMP_HI) begin
            clamp_full = CLAMP_HI;
        end else if (i_err < CLAMP_LO) begin
            clamp_full = CLAMP_LO;
        end else begin
            clamp_full = i_err;
        end
        clamp_err = clamp_full[CLAMP_W-1:0];

        inc_p = OP_P_W'(clamp_err) - OP_P_W'(r_last_err);
        inc_d = OP_D_W'(clamp_err) - (OP_D_W'(r_last_err) <<< 1) + OP_D_W'(r_prev_err);
        pos_d = OP_P_W'(i_err) - OP_P_W'(r_prev_err);

        o_ops = '0;
        case (i_mode)
            MODE_P: begin
                o_ops.p = OP_P_W'(i_err);
            end
            MODE_PI: begin
                o_ops.p       = OP_P_W'(i_err);
                o_ops.i       = sum_new;
                o_ops.sum_hit = sum_hit;
            end
            MODE_POS: begin
                o_ops.p       = OP_P_W'(i_err);
                o_ops.i       = sum_new;
                o_ops.d       = OP_D_W'(pos_d);
                o_ops.sum_hit = sum_hit;
            end
            MODE_INC: begin
                o_ops.p = inc_p;
                o_ops.i = OP_I_W'(clamp_err);
                o_ops.d = inc_d;
            end
            default: begin
                o_ops = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            r_prev_err <= '0;
            r_err_sum  <= '0;
        end else if (i_step) begin
            case (i_mode)
                MODE_PI: begin
                    r_err_sum <= sum_new;
                end
                MODE_POS: begin
                    r_err_sum  <= sum_new;
                    r_last_err <= i_err;
                    r_prev_err <= i_err;
                end
                MODE_INC: begin
                    r_prev_err <= r_last_err;
                    r_last_err <= ERR_W'(clamp_err);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### sv/pid_controller_pos_incr.sv
`timescale 1ns / 1ps
// PID controller with P, PI, positional PID and incremental PID laws, fixed
// point (samples and setpoint Q16.8, gains Q8.8). One measured sample in, one
// drive value out. The block takes one sample per clock cycle while the
// output is not stalled; each result passes the error, operand, product and
// drive registers in order. The error history and saturating error sum are
// updated as each sample leaves the error register. Gain products are
// registered before the final add and saturation. Write the mode, setpoint
// and gain registers only while no sample is in flight.

module pid_controller_pos_incr
    import pid_pi_pkg::*;
#(
    parameter int ERR_CLAMP = 256000
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [MEAS_W-1:0]     i_measured,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [OUT_W-1:0]      o_drive,
    output logic                         o_saturated,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

`include "pid_controller_pos_incr_assert.svh"

    t_mode                      r_mode;
    logic signed [MEAS_W-1:0]   r_target;
    logic signed [GAIN_W-1:0]   r_gain_p;
    logic signed [GAIN_W-1:0]   r_gain_i;
    logic signed [GAIN_W-1:0]   r_gain_d;

    logic                       r_v0;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       en0;
    logic                       en1;
    logic                       en2;
    logic                       en3;

    logic signed [ERR_W-1:0]    r_err;
    t_ops                       ops;
    t_ops                       r_ops;
    logic signed [PROD_P_W-1:0] r_prod_p;
    logic signed [PROD_I_W-1:0] r_prod_i;
    logic signed [PROD_D_W-1:0] r_prod_d;
    logic                       r_sum_hit2;
    logic                       r_sum_hit3;
    logic signed [ACC_W-1:0]    acc;
    logic                       acc_hit;
    logic signed [OUT_W-1:0]    n_drive;
    logic signed [OUT_W-1:0]    r_drive;
    logic                       r_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RST_MODE;
            r_target <= RST_TARGET;
            r_gain_p <= RST_GAIN_P;
            r_gain_i <= RST_GAIN_I;
            r_gain_d <= RST_GAIN_D;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_TARGET: r_target <= i_cfg_data[MEAS_W-1:0];
                CFG_GAIN_P: r_gain_p <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I: r_gain_i <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D: r_gain_d <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // advance a stage when it is empty or the next one advances
    assign en3 = !r_v3 || !i_out_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;

    assign o_in_stall  = !en0;
    assign o_out_valid = r_v3;
    assign o_drive     = r_drive;
    assign o_saturated = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_in_valid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    pid_pi_state #(
        .ERR_CLAMP (ERR_CLAMP)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_v0 && en1),
        .i_mode  (r_mode),
        .i_err   (r_err),
        .o_ops   (ops)
    );

    always_comb begin
        acc = ACC_W'($signed(r_prod_p) >>> FRAC_BITS)
            + ACC_W'($signed(r_prod_i) >>> FRAC_BITS)
            + ACC_W'($signed(r_prod_d) >>> FRAC_BITS);
        acc_hit = 1'b0;
        if (acc > ACC_W'(OUT_MAX)) begin
            n_drive = OUT_MAX;
            acc_hit = 1'b1;
        end else if (acc < ACC_W'(OUT_MIN)) begin
            n_drive = OUT_MIN;
            acc_hit = 1'b1;
        end else begin
            n_drive = acc[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_err <= ERR_W'(r_target) - ERR_W'(i_measured);
        end
        if (en1) begin
            r_ops <= ops;
        end
        if (en2) begin
            r_prod_p   <= r_gain_p * $signed(r_ops.p);
            r_prod_i   <= r_gain_i * $signed(r_ops.i);
            r_prod_d   <= r_gain_d * $signed(r_ops.d);
            r_sum_hit2 <= r_ops.sum_hit;
        end
        if (en3) begin
            r_drive    <= n_drive;
            r_sat      <= r_sum_hit2 || acc_hit;
            r_sum_hit3 <= r_sum_hit2;
        end
    end

    `PID_PI_ASSERT_NOW(a_stall_from_output, o_in_stall, o_out_valid && i_out_stall)
    `PID_PI_ASSERT_NOW(a_sat_drive_at_limit, o_out_valid && o_saturated && !r_sum_hit3,
                       o_drive == OUT_MAX || o_drive == OUT_MIN)
    `PID_PI_ASSERT_NEXT(a_stage_moves_out, r_v2 && (!o_out_valid || !i_out_stall), o_out_valid)
    `PID_PI_ASSERT_NOW(a_empty_after_reset, !$past(i_rst_n), !o_out_valid && !r_v0)

endmodule
